### hdl/uint64_to_decimal_ascii_unit_defines.svh
// Assertion macros shared by the conversion unit.
`ifndef UINT64_TO_DECIMAL_ASCII_UNIT_DEFINES_SVH
`define UINT64_TO_DECIMAL_ASCII_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define U64DA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("u64da assertion failed");
`define U64DA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("u64da assertion failed");
`else
`define U64DA_ASSERT(lbl, clk, rst_n, prop)
`define U64DA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

### hdl/u64da_pkg.sv
package u64da_pkg;

    localparam int NUM_W         = 64;
    localparam int DIGITS        = 20;
    localparam int NIBBLE_W      = 4;
    localparam int BITS_PER_STEP = 4;
    localparam int CONV_STEPS    = NUM_W / BITS_PER_STEP;
    localparam int STEP_CNT_W    = $clog2(CONV_STEPS);
    localparam int IDX_W         = $clog2(DIGITS);
    localparam int CHAR_W        = 6;
    localparam int OUT_DATA_W    = 8;

    localparam logic [STEP_CNT_W-1:0] LAST_STEP = STEP_CNT_W'(CONV_STEPS - 1);
    // '0' is 6'b110000, so a digit 0..9 maps onto the low nibble
    localparam logic [CHAR_W-NIBBLE_W-1:0] CHAR_PREFIX = 2'b11;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIZE,
        ST_EMIT
    } u64da_state_t;

    typedef struct packed {
        logic load;   // capture input item, clear digit register
        logic step;   // one shift-add-3 step
        logic size;   // find most significant digit
        logic emit;   // move one digit into the output register
    } u64da_cmd_t;

    typedef struct packed {
        logic idx_zero;  // digit pointer on the least significant digit
        logic out_free;  // output register can take a digit this cycle
    } u64da_status_t;

endpackage

### hdl/uint64_to_decimal_ascii_unit.sv
// Unsigned 64-bit to decimal ASCII converter. Each item on the slave stream
// is one 64-bit value; the master stream returns its decimal text, one
// character per item, most significant digit first, no leading zeros, with
// tlast on the final digit (zero gives the single character '0', the largest
// value 20 characters). The value is turned into 20 BCD digits by a
// shift-add-3 unit that consumes 4 bits per cycle; the leading digit is
// then located in a separate step, and the digits leave at one per cycle
// while the master stream takes them. The input is held until the last
// digit has moved into the output register. That last character sits in
// an output register, so the next value is accepted while it still waits
// for tready.
module uint64_to_decimal_ascii_unit
    import u64da_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [NUM_W-1:0]      s_axis_tdata,   // [63:0] number
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [5:0] digit_char, [7:6] zero
    output logic                  m_axis_tlast    // last_digit
);

    u64da_cmd_t         cmd;
    u64da_status_t      status;
    logic [CHAR_W-1:0]  digit_char;

    u64da_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    u64da_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .number     (s_axis_tdata),
        .cmd        (cmd),
        .status     (status),
        .out_ready  (m_axis_tready),
        .out_valid  (m_axis_tvalid),
        .digit_char (digit_char),
        .last_digit (m_axis_tlast)
    );

    // pad the 6-bit character code to a whole byte
    assign m_axis_tdata = {{(OUT_DATA_W-CHAR_W){1'b0}}, digit_char};

endmodule

### hdl/u64da_ctrl.sv
`include "uint64_to_decimal_ascii_unit_defines.svh"

module u64da_ctrl
    import u64da_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  u64da_status_t status,
    output u64da_cmd_t    cmd
);

    u64da_state_t            state_reg, state_next;
    logic [STEP_CNT_W-1:0]   cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (in_valid)
                begin
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    state_next = ST_SIZE;
                end
            end
            ST_SIZE:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free && status.idx_zero)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_CONV:
            begin
                cmd.step = 1'b1;
            end
            ST_SIZE:
            begin
                cmd.size = 1'b1;
            end
            ST_EMIT:
            begin
                cmd.emit = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    `U64DA_ASSERT_NEXT(a_conv_starts_at_zero, clk, rst_n,
        cmd.load, (state_reg == ST_CONV) && (cnt_reg == '0))
    `U64DA_ASSERT_NEXT(a_conv_then_size, clk, rst_n,
        (state_reg == ST_CONV) && (cnt_reg == LAST_STEP), state_reg == ST_SIZE)
    `U64DA_ASSERT_NEXT(a_last_emit_ends_run, clk, rst_n,
        cmd.emit && status.idx_zero, state_reg == ST_IDLE)

endmodule

### hdl/u64da_dpath.sv
`include "uint64_to_decimal_ascii_unit_defines.svh"

module u64da_dpath
    import u64da_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [NUM_W-1:0]      number,
    input  u64da_cmd_t            cmd,
    output u64da_status_t         status,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic [CHAR_W-1:0]     digit_char,
    output logic                  last_digit
);

    localparam int WORK_W = DIGITS * NIBBLE_W + NUM_W;

    logic [NUM_W-1:0]                bin_reg;
    logic [DIGITS-1:0][NIBBLE_W-1:0] bcd_reg;
    logic [IDX_W-1:0]                idx_reg, idx_next;
    logic                            out_valid_reg;
    logic [CHAR_W-1:0]               out_char_reg;
    logic                            out_last_reg;
    logic [WORK_W-1:0]               work;
    logic [IDX_W-1:0]                msd;

    // shift-add-3 over BITS_PER_STEP input bits
    always_comb
    begin
        work = {bcd_reg, bin_reg};
        for (int s = 0; s < BITS_PER_STEP; s++)
        begin
            for (int d = 0; d < DIGITS; d++)
            begin
                if (work[NUM_W + d*NIBBLE_W +: NIBBLE_W] >= NIBBLE_W'(5))
                begin
                    work[NUM_W + d*NIBBLE_W +: NIBBLE_W] =
                        work[NUM_W + d*NIBBLE_W +: NIBBLE_W] + NIBBLE_W'(3);
                end
            end
            work = work << 1;
        end
    end

    // highest nonzero digit; zero value keeps a single digit
    always_comb
    begin
        msd = '0;
        for (int d = 0; d < DIGITS; d++)
        begin
            if (bcd_reg[d] != '0)
            begin
                msd = IDX_W'(d);
            end
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.size)
        begin
            idx_next = msd;
        end
        else if (cmd.emit && (idx_reg != '0))
        begin
            idx_next = idx_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            bin_reg <= number;
            bcd_reg <= '0;
        end
        else if (cmd.step)
        begin
            {bcd_reg, bin_reg} <= work;
        end
        idx_reg <= idx_next;
        if (cmd.emit)
        begin
            out_char_reg <= {CHAR_PREFIX, bcd_reg[idx_reg]};
            out_last_reg <= (idx_reg == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.idx_zero = (idx_reg == '0);
    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign digit_char      = out_char_reg;
    assign last_digit      = out_last_reg;

    `U64DA_ASSERT(a_digit_is_decimal, clk, rst_n,
        !out_valid_reg || (out_char_reg[NIBBLE_W-1:0] <= NIBBLE_W'(9)))
    `U64DA_ASSERT_NEXT(a_msd_nonzero, clk, rst_n,
        cmd.size, (idx_reg == '0) || (bcd_reg[idx_reg] != '0))
    `U64DA_ASSERT(a_emit_needs_free_slot, clk, rst_n,
        !cmd.emit || status.out_free)

endmodule
